/* src/lom_pkg.sv */
// shared types and constants for the limit order matcher
`default_nettype none
package lom_pkg;

   localparam int IDX_W = 6;
   localparam int ID_W = 32;
   localparam int PRICE_W = 32;
   localparam int QTY_W = 24;
   localparam int SEQ_W = 32;

   localparam logic SIDE_BUY = 1'b0;
   localparam logic SIDE_SELL = 1'b1;
   localparam logic KIND_TRADE = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   typedef enum logic [1:0] {
      CMD_NONE,
      CMD_FILL,
      CMD_REST
   } cmd_op_type;

   // update broadcast to all cells, the matching cell applies it
   typedef struct packed {
      cmd_op_type         op;
      logic [IDX_W-1:0]   idx;
      logic [ID_W-1:0]    order_id;
      logic               side;
      logic [PRICE_W-1:0] price;
      logic [QTY_W-1:0]   qty;
      logic [SEQ_W-1:0]   arrival;
   } cmd_type;

   // search token handed from cell to cell
   typedef struct packed {
      logic               live;
      logic               best_hit;
      logic [IDX_W-1:0]   best_idx;
      logic [PRICE_W-1:0] best_price;
      logic [SEQ_W-1:0]   best_age;
      logic [ID_W-1:0]    best_id;
      logic [QTY_W-1:0]   best_qty;
      logic               dup;
      logic               free_hit;
      logic [IDX_W-1:0]   free_idx;
   } token_type;

endpackage
`default_nettype wire

/* src/lom_cell.sv */
// one book entry plus one stage of the search chain
`default_nettype none
module lom_cell #(
   parameter int CELL_INDEX = 0
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire lom_pkg::cmd_type           cmd,
   input  wire logic                       taker_side,
   input  wire logic [lom_pkg::ID_W-1:0]   taker_id,
   input  wire logic [lom_pkg::SEQ_W-1:0]  arrival_now,
   input  wire lom_pkg::token_type         tok_in,
   output lom_pkg::token_type              tok_out
);
   localparam logic [lom_pkg::IDX_W-1:0] MY_IDX = CELL_INDEX[lom_pkg::IDX_W-1:0];

   logic                          valid_ff;
   logic [lom_pkg::ID_W-1:0]      id_ff;
   logic                          side_ff;
   logic [lom_pkg::PRICE_W-1:0]   price_ff;
   logic [lom_pkg::QTY_W-1:0]     qty_ff;
   logic [lom_pkg::SEQ_W-1:0]     arrival_ff;
   lom_pkg::token_type            tok_ff;
   lom_pkg::token_type            tok_in_next;

   logic                          opp;
   logic                          better;
   logic [lom_pkg::SEQ_W-1:0]     age;
   logic                          hit;

   assign hit = (cmd.idx == MY_IDX);
   assign age = arrival_now - arrival_ff;
   assign opp = valid_ff && (side_ff != taker_side);

   always_comb begin
      better = 1'b0;
      if (!tok_in.best_hit) begin
         better = 1'b1;
      end else if (taker_side == lom_pkg::SIDE_BUY) begin
         better = price_ff < tok_in.best_price;
      end else begin
         better = price_ff > tok_in.best_price;
      end
      if (tok_in.best_hit && price_ff == tok_in.best_price && age > tok_in.best_age) begin
         better = 1'b1;
      end
   end

   always_comb begin
      tok_in_next = tok_in;
      if (opp && better) begin
         tok_in_next.best_hit   = 1'b1;
         tok_in_next.best_idx   = MY_IDX;
         tok_in_next.best_price = price_ff;
         tok_in_next.best_age   = age;
         tok_in_next.best_id    = id_ff;
         tok_in_next.best_qty   = qty_ff;
      end
      if (valid_ff && id_ff == taker_id) begin
         tok_in_next.dup = 1'b1;
      end
      // lowest free entry wins since the token starts at cell zero
      if (!valid_ff && !tok_in.free_hit) begin
         tok_in_next.free_hit = 1'b1;
         tok_in_next.free_idx = MY_IDX;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         tok_ff   <= '0;
      end else begin
         tok_ff <= tok_in_next;
         if (hit && cmd.op == lom_pkg::CMD_FILL) begin
            valid_ff <= (cmd.qty != '0);
         end else if (hit && cmd.op == lom_pkg::CMD_REST) begin
            valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (hit && cmd.op == lom_pkg::CMD_FILL) begin
         qty_ff <= cmd.qty;
      end else if (hit && cmd.op == lom_pkg::CMD_REST) begin
         id_ff      <= cmd.order_id;
         side_ff    <= cmd.side;
         price_ff   <= cmd.price;
         qty_ff     <= cmd.qty;
         arrival_ff <= cmd.arrival;
      end
   end

   assign tok_out = tok_ff;

endmodule
`default_nettype wire

/* src/limit_order_matcher.sv */
// price-time priority matcher: top level with the order sequencer and the cell chain
`default_nettype none
// Each book entry lives in its own cell. A search token walks the row of cells one cell
// a cycle, picking the best opposite-side entry (best price, then oldest), spotting a
// duplicate id and the lowest free entry. Every trade costs one sweep, a decide step and
// a write-back of the entry, and the next order is taken only after the final sweep of
// the current order is decided. Results leave through one output register; a stalled
// result holds the sequencer. No clearing pass is needed after reset.
module limit_order_matcher #(
   parameter int BOOK_DEPTH = 32
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic [lom_pkg::ID_W-1:0]    req_order_id,
   input  wire logic                        req_side,
   input  wire logic                        req_is_market,
   input  wire logic [lom_pkg::PRICE_W-1:0] req_limit_price,
   input  wire logic [lom_pkg::QTY_W-1:0]   req_quantity,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic                             rsp_record_kind,
   output logic [lom_pkg::ID_W-1:0]         rsp_maker_id,
   output logic [lom_pkg::ID_W-1:0]         rsp_taker_id,
   output logic [lom_pkg::PRICE_W-1:0]      rsp_trade_price,
   output logic [lom_pkg::QTY_W-1:0]        rsp_trade_qty,
   output logic [lom_pkg::SEQ_W-1:0]        rsp_trade_seq,
   output logic                             rsp_accepted,
   output logic [lom_pkg::QTY_W-1:0]        rsp_filled_qty,
   output logic [lom_pkg::QTY_W-1:0]        rsp_remaining_qty,
   output logic                             rsp_rested,
   output logic                             rsp_book_full,
   output logic                             rsp_last
);
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SWEEP,
      ST_DECIDE,
      ST_APPLY
   } state_type;

   state_type                     state_ff;
   logic                          start_ff;
   logic                          first_ff;
   lom_pkg::cmd_type              cmd_ff;
   lom_pkg::token_type            res_ff;
   logic [lom_pkg::ID_W-1:0]      id_ff;
   logic                          side_ff;
   logic                          market_ff;
   logic [lom_pkg::PRICE_W-1:0]   limit_ff;
   logic [lom_pkg::QTY_W-1:0]     qty_ff;
   logic [lom_pkg::QTY_W-1:0]     rem_ff;
   logic [lom_pkg::SEQ_W-1:0]     arrival_ff;
   logic [lom_pkg::SEQ_W-1:0]     trade_ctr_ff;

   logic                          rsp_valid_ff;
   logic                          rsp_kind_ff;
   logic [lom_pkg::ID_W-1:0]      rsp_maker_ff;
   logic [lom_pkg::ID_W-1:0]      rsp_taker_ff;
   logic [lom_pkg::PRICE_W-1:0]   rsp_price_ff;
   logic [lom_pkg::QTY_W-1:0]     rsp_tqty_ff;
   logic [lom_pkg::SEQ_W-1:0]     rsp_seq_ff;
   logic                          rsp_acc_ff;
   logic [lom_pkg::QTY_W-1:0]     rsp_filled_ff;
   logic [lom_pkg::QTY_W-1:0]     rsp_rem_ff;
   logic                          rsp_rested_ff;
   logic                          rsp_full_ff;

   lom_pkg::token_type            chain_tok [BOOK_DEPTH+1];
   lom_pkg::token_type            end_tok;

   logic                          req_beat;
   logic                          rsp_free;
   logic                          crosses;
   logic [lom_pkg::QTY_W-1:0]     fill;

   assign chain_tok[0] = '{live: start_ff, default: '0};
   assign end_tok = chain_tok[BOOK_DEPTH];

   for (genvar g = 0; g < BOOK_DEPTH; g++) begin : g_cell
      lom_cell #(
         .CELL_INDEX(g)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .cmd         (cmd_ff),
         .taker_side  (side_ff),
         .taker_id    (id_ff),
         .arrival_now (arrival_ff),
         .tok_in      (chain_tok[g]),
         .tok_out     (chain_tok[g+1])
      );
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign req_beat  = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      if (market_ff) begin
         crosses = 1'b1;
      end else if (side_ff == lom_pkg::SIDE_BUY) begin
         crosses = res_ff.best_price <= limit_ff;
      end else begin
         crosses = res_ff.best_price >= limit_ff;
      end
      fill = (rem_ff < res_ff.best_qty) ? rem_ff : res_ff.best_qty;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         start_ff     <= 1'b0;
         first_ff     <= 1'b0;
         cmd_ff       <= '{op: lom_pkg::CMD_NONE, default: '0};
         arrival_ff   <= '0;
         trade_ctr_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         start_ff  <= 1'b0;
         cmd_ff.op <= lom_pkg::CMD_NONE;
         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_beat) begin
                  id_ff     <= req_order_id;
                  side_ff   <= req_side;
                  market_ff <= req_is_market;
                  limit_ff  <= req_limit_price;
                  qty_ff    <= req_quantity;
                  rem_ff    <= req_quantity;
                  first_ff  <= 1'b1;
                  start_ff  <= 1'b1;
                  state_ff  <= ST_SWEEP;
               end
            end
            ST_SWEEP: begin
               if (end_tok.live) begin
                  res_ff   <= end_tok;
                  state_ff <= ST_DECIDE;
               end
            end
            ST_DECIDE: begin
               if (rsp_free) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_taker_ff  <= id_ff;
                  rsp_maker_ff  <= '0;
                  rsp_price_ff  <= '0;
                  rsp_tqty_ff   <= '0;
                  rsp_seq_ff    <= '0;
                  rsp_acc_ff    <= 1'b0;
                  rsp_filled_ff <= '0;
                  rsp_rem_ff    <= '0;
                  rsp_rested_ff <= 1'b0;
                  rsp_full_ff   <= 1'b0;
                  rsp_kind_ff   <= lom_pkg::KIND_SUMMARY;
                  if (first_ff && (qty_ff == '0 || res_ff.dup)) begin
                     state_ff <= ST_IDLE;
                  end else if (rem_ff != '0 && res_ff.best_hit && crosses) begin
                     rsp_kind_ff  <= lom_pkg::KIND_TRADE;
                     rsp_maker_ff <= res_ff.best_id;
                     rsp_price_ff <= res_ff.best_price;
                     rsp_tqty_ff  <= fill;
                     rsp_seq_ff   <= trade_ctr_ff;
                     trade_ctr_ff <= trade_ctr_ff + 1'b1;
                     rem_ff       <= rem_ff - fill;
                     cmd_ff.op    <= lom_pkg::CMD_FILL;
                     cmd_ff.idx   <= res_ff.best_idx;
                     cmd_ff.qty   <= res_ff.best_qty - fill;
                     first_ff     <= 1'b0;
                     state_ff     <= ST_APPLY;
                  end else begin
                     rsp_acc_ff    <= 1'b1;
                     rsp_filled_ff <= qty_ff - rem_ff;
                     rsp_rem_ff    <= rem_ff;
                     if (rem_ff != '0 && !market_ff) begin
                        if (res_ff.free_hit) begin
                           cmd_ff.op       <= lom_pkg::CMD_REST;
                           cmd_ff.idx      <= res_ff.free_idx;
                           cmd_ff.order_id <= id_ff;
                           cmd_ff.side     <= side_ff;
                           cmd_ff.price    <= limit_ff;
                           cmd_ff.qty      <= rem_ff;
                           cmd_ff.arrival  <= arrival_ff;
                           arrival_ff      <= arrival_ff + 1'b1;
                           rsp_rested_ff   <= 1'b1;
                        end else begin
                           rsp_full_ff <= 1'b1;
                        end
                     end
                     state_ff <= ST_IDLE;
                  end
               end
            end
            ST_APPLY: begin
               // entry written back this cycle, next sweep sees it
               start_ff <= 1'b1;
               state_ff <= ST_SWEEP;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_record_kind   = rsp_kind_ff;
   assign rsp_maker_id      = rsp_maker_ff;
   assign rsp_taker_id      = rsp_taker_ff;
   assign rsp_trade_price   = rsp_price_ff;
   assign rsp_trade_qty     = rsp_tqty_ff;
   assign rsp_trade_seq     = rsp_seq_ff;
   assign rsp_accepted      = rsp_acc_ff;
   assign rsp_filled_qty    = rsp_filled_ff;
   assign rsp_remaining_qty = rsp_rem_ff;
   assign rsp_rested        = rsp_rested_ff;
   assign rsp_book_full     = rsp_full_ff;
   assign rsp_last          = rsp_kind_ff;

   a_accept_starts_sweep: assert property (@(posedge clock) disable iff (reset)
      req_beat |=> start_ff && state_ff == ST_SWEEP)
      else $error("accepted order did not start a sweep");

   a_token_only_in_sweep: assert property (@(posedge clock) disable iff (reset)
      end_tok.live |-> state_ff == ST_SWEEP)
      else $error("search token finished outside a sweep");

   a_rest_only_accepted: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_rested_ff |-> rsp_acc_ff && !rsp_full_ff)
      else $error("rested summary not marked accepted");

   a_write_then_sweep: assert property (@(posedge clock) disable iff (reset)
      cmd_ff.op == lom_pkg::CMD_FILL |-> state_ff == ST_APPLY)
      else $error("fill write-back outside apply");

endmodule
`default_nettype wire
